// ===== src/vpt_pkg.sv =====
// ----------------------------------------------------------------------------
// vpt_pkg: shared definitions for virtual-to-physical translation
// Field widths, page geometry, operation and register codes, and the
// structs that pass between the translation modules.
// ----------------------------------------------------------------------------
package vpt_pkg;

  // Payload field widths.
  localparam int VA_W    = 32;
  localparam int IDX_W   = 6;
  localparam int FRAME_W = 8;
  localparam int PA_W    = 12;

  // Page geometry. The page size is a power of two, so the page number is a
  // shift of the address and the offset is a mask.
  localparam int PAGE_BYTES = 128;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int VPAGE_W    = VA_W - PAGE_SHIFT;

  // Frames at or beyond this count are not backed by memory.
  localparam int FRAME_COUNT = 32;

  // Default sizes of the two translation stores.
  localparam int DEF_TLB_ENTRIES   = 4;
  localparam int DEF_TABLE_ENTRIES = 64;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int PT_LEN_W   = 7;

  // Operation codes carried by a request word.
  typedef enum logic [1:0] {
    OP_TRANSLATE   = 2'd0,
    OP_WRITE_TLB   = 2'd1,
    OP_WRITE_TABLE = 2'd2
  } op_t;

  // Configuration register indexes (word address bit of paddr).
  typedef enum logic [0:0] {
    REG_USE_TLB = 1'b0,
    REG_PT_LEN  = 1'b1
  } reg_idx_t;

  // Configuration register values.
  typedef struct packed {
    logic                use_tlb;
    logic [PT_LEN_W-1:0] page_table_length;
  } cfg_t;

  // TLB slot write command.
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic               valid;
    logic [VPAGE_W-1:0] vpage;
    logic [FRAME_W-1:0] frame;
  } tlb_wr_t;

  // TLB lookup answer.
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlb_hit_t;

endpackage

// ===== src/vpt_cmd_if.sv =====
// ----------------------------------------------------------------------------
// vpt_cmd_if: request channel
// Carries one translate or store-write request word with valid/ready.
// ----------------------------------------------------------------------------
interface vpt_cmd_if;
  import vpt_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [VA_W-1:0]    virtual_address;
  logic [IDX_W-1:0]   entry_index;
  logic               entry_valid;
  logic [VPAGE_W-1:0] entry_virtual_page;
  logic [FRAME_W-1:0] entry_frame;

  modport source (
    output valid, operation, virtual_address, entry_index, entry_valid,
           entry_virtual_page, entry_frame,
    input  ready
  );

  modport sink (
    input  valid, operation, virtual_address, entry_index, entry_valid,
           entry_virtual_page, entry_frame,
    output ready
  );
endinterface

// ===== src/vpt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vpt_rsp_if: result channel
// Carries one translation result word with valid/ready.
// ----------------------------------------------------------------------------
interface vpt_rsp_if;
  import vpt_pkg::*;

  logic            valid;
  logic            ready;
  logic [PA_W-1:0] physical_address;
  logic            fault;

  modport source (
    output valid, physical_address, fault,
    input  ready
  );

  modport sink (
    input  valid, physical_address, fault,
    output ready
  );
endinterface

// ===== src/vpt_cfg.sv =====
// ----------------------------------------------------------------------------
// vpt_cfg: configuration registers
// APB-style register file holding the lookup mode and the page table length.
// ----------------------------------------------------------------------------
module vpt_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vpt_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [vpt_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [vpt_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output vpt_pkg::cfg_t                   cfg
);
  import vpt_pkg::*;

  logic     wr_en;
  reg_idx_t reg_idx;

  // Every access completes without wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_USE_TLB: cfg.use_tlb <= pwdata[0];
        REG_PT_LEN:  cfg.page_table_length <= pwdata[PT_LEN_W-1:0];
        default:     cfg <= cfg;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_USE_TLB: prdata = {{(APB_DATA_W-1){1'b0}}, cfg.use_tlb};
      REG_PT_LEN:  prdata = {{(APB_DATA_W-PT_LEN_W){1'b0}}, cfg.page_table_length};
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== src/vpt_tlb.sv =====
// ----------------------------------------------------------------------------
// vpt_tlb: fully associative TLB
// Slots in flip-flops with a parallel compare of every slot; the lowest
// numbered valid matching slot supplies the frame.
// ----------------------------------------------------------------------------
module vpt_tlb #(
  parameter int TLB_ENTRIES = vpt_pkg::DEF_TLB_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  vpt_pkg::tlb_wr_t             wr,
  input  logic [vpt_pkg::VPAGE_W-1:0]  page,
  output vpt_pkg::tlb_hit_t            lookup
);
  import vpt_pkg::*;

  localparam int SLOT_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  logic [TLB_ENTRIES-1:0] slot_valid;
  logic [VPAGE_W-1:0]     slot_vpage [TLB_ENTRIES];
  logic [FRAME_W-1:0]     slot_frame [TLB_ENTRIES];
  logic                   wr_in_range;
  logic [SLOT_W-1:0]      wr_slot;

  assign wr_in_range = 32'(wr.idx) < 32'(TLB_ENTRIES);
  assign wr_slot     = SLOT_W'(wr.idx);

  // Valid marks are cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr.en && wr_in_range) begin
      slot_valid[wr_slot] <= wr.valid;
    end
  end

  // Slot payload.
  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      slot_vpage[wr_slot] <= wr.vpage;
      slot_frame[wr_slot] <= wr.frame;
    end
  end

  // Parallel compare; scanning downward leaves the lowest matching slot.
  always_comb begin
    lookup = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid[i] && (slot_vpage[i] == page)) begin
        lookup.hit   = 1'b1;
        lookup.frame = slot_frame[i];
      end
    end
  end

endmodule

// ===== src/virtual_to_physical_translate.sv =====
// ----------------------------------------------------------------------------
// virtual_to_physical_translate: TLB and linear page table translation
// Translates 32-bit virtual addresses to 12-bit physical addresses and takes
// write words that load TLB slots and page table entries.
//
//   Channel  Kind       Direction  Contents
//   cmd      word       in         operation, address, entry to store
//   rsp      word       out        physical_address, fault
//   apb      registers  in/out     use_tlb (0x0), page_table_length (0x4)
//
// One word is taken every cycle while cmd.ready is high. A translate word is
// registered into the lookup stage at accept and moves on to the result register
// when the result stage advances: the page table read is registered at accept,
// the TLB compare and fault checks sit between that register and the result register.
// Store writes take effect at accept and give no result.
// Synchronous reset clears both stores (valid marks in flip-flops), the
// configuration registers and the pipeline; no clearing pass is needed.
// A stalled result holds the pipeline; cmd.ready drops only when both stages
// are full and the result is not taken.
// ----------------------------------------------------------------------------
module virtual_to_physical_translate #(
  parameter int TLB_ENTRIES   = vpt_pkg::DEF_TLB_ENTRIES,
  parameter int TABLE_ENTRIES = vpt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  vpt_cmd_if.sink                         cmd,
  vpt_rsp_if.source                       rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vpt_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [vpt_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [vpt_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import vpt_pkg::*;

  // Only the first 2**IDX_W table entries can ever be written.
  localparam int TBL_USED  = (TABLE_ENTRIES < (1 << IDX_W)) ? TABLE_ENTRIES : (1 << IDX_W);
  localparam int TBL_IDX_W = (TBL_USED > 1) ? $clog2(TBL_USED) : 1;
  localparam int TBL_DEPTH = 1 << TBL_IDX_W;

  cfg_t                   cfg;
  tlb_wr_t                tlb_wr;
  tlb_hit_t               tlb_lookup;
  op_t                    cmd_op;
  logic                   cmd_accept;
  logic                   xlate_accept;
  logic                   advance;
  logic [VPAGE_W-1:0]     cmd_page;
  logic [TBL_IDX_W-1:0]   rd_idx;
  logic [TBL_IDX_W-1:0]   wr_idx;
  logic                   page_in_range;
  logic                   tbl_wr_en;

  // Page table store.
  logic [TBL_DEPTH-1:0]   tbl_valid;
  logic [FRAME_W-1:0]     tbl_frame [TBL_DEPTH];

  // Lookup stage registers.
  logic                   s1_valid;
  logic [VPAGE_W-1:0]     s1_page;
  logic [PAGE_SHIFT-1:0]  s1_offset;
  logic                   s1_tbl_hit;
  logic [FRAME_W-1:0]     s1_tbl_frame;

  // Result stage.
  logic                   found;
  logic [FRAME_W-1:0]     frame;
  logic                   fault_next;
  logic [PA_W-1:0]        pa_next;
  logic                   rsp_valid;
  logic [PA_W-1:0]        rsp_pa;
  logic                   rsp_fault;

  // Configuration registers.
  vpt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake and decode of the incoming word.
  assign advance      = !rsp_valid || rsp.ready;
  assign cmd.ready    = !s1_valid || advance;
  assign cmd_accept   = cmd.valid && cmd.ready;
  assign cmd_op       = op_t'(cmd.operation);
  assign xlate_accept = cmd_accept && (cmd_op == OP_TRANSLATE);
  assign cmd_page     = cmd.virtual_address[VA_W-1:PAGE_SHIFT];
  assign rd_idx       = TBL_IDX_W'(cmd_page);
  assign wr_idx       = TBL_IDX_W'(cmd.entry_index);

  // The page must be below both the configured length and the table size.
  // Entries beyond the writable range always stay invalid.
  assign page_in_range =
    (cmd_page < {{(VPAGE_W-PT_LEN_W){1'b0}}, cfg.page_table_length}) &&
    (32'(cmd_page) < 32'(TBL_USED));

  assign tbl_wr_en = cmd_accept && (cmd_op == OP_WRITE_TABLE) &&
                     (32'(cmd.entry_index) < 32'(TABLE_ENTRIES));

  // TLB write command.
  always_comb begin
    tlb_wr.en    = cmd_accept && (cmd_op == OP_WRITE_TLB);
    tlb_wr.idx   = cmd.entry_index;
    tlb_wr.valid = cmd.entry_valid;
    tlb_wr.vpage = cmd.entry_virtual_page;
    tlb_wr.frame = cmd.entry_frame;
  end

  vpt_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_tlb (
    .clk    (clk),
    .rst    (rst),
    .wr     (tlb_wr),
    .page   (s1_page),
    .lookup (tlb_lookup)
  );

  // Page table valid marks, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
    end else if (tbl_wr_en) begin
      tbl_valid[wr_idx] <= cmd.entry_valid;
    end
  end

  // Page table frames: one write port, registered read at accept.
  always_ff @(posedge clk) begin
    if (tbl_wr_en) begin
      tbl_frame[wr_idx] <= cmd.entry_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (xlate_accept) begin
      s1_tbl_frame <= tbl_frame[rd_idx];
      s1_tbl_hit   <= page_in_range && tbl_valid[rd_idx];
      s1_page      <= cmd_page;
      s1_offset    <= cmd.virtual_address[PAGE_SHIFT-1:0];
    end
  end

  // Lookup stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= xlate_accept;
    end
  end

  // Pick the source of the frame and check it.
  always_comb begin
    found      = cfg.use_tlb ? tlb_lookup.hit : s1_tbl_hit;
    frame      = cfg.use_tlb ? tlb_lookup.frame : s1_tbl_frame;
    fault_next = !found || (9'(frame) >= 9'(FRAME_COUNT));
    pa_next    = fault_next ? '0 : PA_W'({frame, s1_offset});
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      rsp_pa    <= pa_next;
      rsp_fault <= fault_next;
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.physical_address = rsp_pa;
  assign rsp.fault            = rsp_fault;

  // A faulting result never carries an address.
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_fault |-> rsp_pa == '0)
    else $error("fault result with nonzero address");

  // A full lookup stage behind a stalled result blocks new words.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |-> !cmd.ready)
    else $error("word accepted while pipeline is full");

  // A taken translate word occupies the lookup stage next cycle.
  a_xlate_enters: assert property (@(posedge clk) disable iff (rst)
    xlate_accept |=> s1_valid)
    else $error("translate word lost at lookup stage");

  // A stalled lookup stage keeps its page.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_page))
    else $error("stalled lookup stage changed");

  // A stage moving forward always lands in the result register.
  a_result_fills: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> rsp_valid)
    else $error("translate result dropped");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for virtual_to_physical_translate
// Drives request words (translations and TLB or page table loads) and APB
// register writes, predicts every translation from a behavioral copy of both
// stores and the registers, and checks each result word in order. Both
// channels idle and stall in random bursts. One phase holds the result
// channel off for a long stretch. The last phase runs at full rate.
// ----------------------------------------------------------------------------
module tb_top;
  import vpt_pkg::*;

  localparam int TLB_SLOTS    = DEF_TLB_ENTRIES;
  localparam int TABLE_SLOTS  = DEF_TABLE_ENTRIES;
  localparam int HOT_PAGES    = 72;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 8;

  // Operation code that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One expected translation result.
  typedef struct packed {
    logic [PA_W-1:0] pa;
    logic            fault;
  } xlat_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  vpt_cmd_if cmd ();
  vpt_rsp_if rsp ();

  virtual_to_physical_translate DUT (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Behavioral copy of the translation stores and the registers.
  logic               tlb_valid [TLB_SLOTS];
  logic [VPAGE_W-1:0] tlb_page  [TLB_SLOTS];
  logic [FRAME_W-1:0] tlb_frame [TLB_SLOTS];
  logic               table_valid [TABLE_SLOTS];
  logic [FRAME_W-1:0] table_frame [TABLE_SLOTS];
  logic               cfg_use_tlb = 1'b0;
  logic [PT_LEN_W-1:0] cfg_table_len = '0;

  xlat_t translation_q[$];
  int    mismatches = 0;
  bit    jitter_on = 1'b0;
  int    hold_left = 0;

  initial begin
    for (int i = 0; i < TLB_SLOTS; i++) begin
      tlb_valid[i] = 1'b0;
      tlb_page[i]  = '0;
      tlb_frame[i] = '0;
    end
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      table_valid[i] = 1'b0;
      table_frame[i] = '0;
    end
  end

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Expected outcome of translating one address with the current state.
  function automatic xlat_t predict_translation(logic [VA_W-1:0] va);
    logic [VPAGE_W-1:0]            page;
    logic [PAGE_SHIFT-1:0]         offset;
    logic [FRAME_W-1:0]            frame;
    logic [FRAME_W+PAGE_SHIFT-1:0] full_pa;
    bit                            found;
    xlat_t                         r;
    page   = va[VA_W-1:PAGE_SHIFT];
    offset = va[PAGE_SHIFT-1:0];
    frame  = '0;
    found  = 1'b0;
    if (cfg_use_tlb) begin
      // The lowest-numbered valid matching slot wins.
      for (int i = 0; i < TLB_SLOTS; i++) begin
        if (!found && tlb_valid[i] && tlb_page[i] == page) begin
          found = 1'b1;
          frame = tlb_frame[i];
        end
      end
    end else if (page < cfg_table_len && page < TABLE_SLOTS) begin
      if (table_valid[page[IDX_W-1:0]]) begin
        found = 1'b1;
        frame = table_frame[page[IDX_W-1:0]];
      end
    end
    if (!found || frame >= FRAME_COUNT) begin
      r.pa    = '0;
      r.fault = 1'b1;
    end else begin
      full_pa = {frame, offset};
      r.pa    = full_pa[PA_W-1:0];
      r.fault = 1'b0;
    end
    return r;
  endfunction

  // Apply one accepted request word to the stores or queue its result.
  function automatic void absorb_word(logic [1:0] op, logic [VA_W-1:0] va,
                                      logic [IDX_W-1:0] idx, logic ev,
                                      logic [VPAGE_W-1:0] vp,
                                      logic [FRAME_W-1:0] fr);
    case (op)
      OP_TRANSLATE: translation_q.push_back(predict_translation(va));
      OP_WRITE_TLB: begin
        if (idx < TLB_SLOTS) begin
          tlb_valid[idx] = ev;
          tlb_page[idx]  = vp;
          tlb_frame[idx] = fr;
        end
      end
      OP_WRITE_TABLE: begin
        table_valid[idx] = ev;
        table_frame[idx] = fr;
      end
      default: ;
    endcase
  endfunction

  // Check each result word, then record each accepted request word.
  always @(posedge clk) begin : scoreboard
    xlat_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (translation_q.size() == 0) begin
          log_mismatch($sformatf("result pa=%03h fault=%0b with none expected",
                                 rsp.physical_address, rsp.fault));
        end else begin
          want = translation_q.pop_front();
          if (rsp.physical_address !== want.pa || rsp.fault !== want.fault)
            log_mismatch($sformatf("expected pa=%03h fault=%0b, got pa=%03h fault=%0b",
                                   want.pa, want.fault, rsp.physical_address,
                                   rsp.fault));
        end
      end
      if (cmd.valid && cmd.ready)
        absorb_word(cmd.operation, cmd.virtual_address, cmd.entry_index,
                    cmd.entry_valid, cmd.entry_virtual_page, cmd.entry_frame);
    end
  end

  // Result receiver: long hold-offs on request, otherwise random stall bursts.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else if (jitter_on && $urandom_range(0, 9) == 0) begin
        rsp.ready <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Offer one request word and wait until it is taken.
  task automatic send_word(logic [1:0] op, logic [VA_W-1:0] va,
                           logic [IDX_W-1:0] idx, logic ev,
                           logic [VPAGE_W-1:0] vp, logic [FRAME_W-1:0] fr);
    if (jitter_on && $urandom_range(0, 7) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    cmd.valid              <= 1'b1;
    cmd.operation          <= op;
    cmd.virtual_address    <= va;
    cmd.entry_index        <= idx;
    cmd.entry_valid        <= ev;
    cmd.entry_virtual_page <= vp;
    cmd.entry_frame        <= fr;
    do @(posedge clk); while (!cmd.ready);
  endtask

  task automatic translate_addr(logic [VA_W-1:0] va);
    send_word(OP_TRANSLATE, va, '0, 1'b0, '0, '0);
  endtask

  // Stop offering words and wait until every translation has returned.
  task automatic drain_translations();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (translation_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of one register, then read it back.
  task automatic write_register(reg_idx_t r, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] mask;
    logic [APB_DATA_W-1:0] got;
    mask    = (r == REG_USE_TLB) ? 32'h1 : 32'h7F;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (r == REG_USE_TLB) cfg_use_tlb = value[0];
    else cfg_table_len = value[PT_LEN_W-1:0];
    if (got !== (value & mask))
      log_mismatch($sformatf("register %0d read %08h, expected %08h",
                             r, got, value & mask));
  endtask

  // One random word: mostly loads and translations that reach stored pages.
  task automatic send_random_word();
    int                 pick;
    logic [1:0]         op;
    logic [VA_W-1:0]    va;
    logic [IDX_W-1:0]   idx;
    logic               ev;
    logic [VPAGE_W-1:0] vp;
    logic [FRAME_W-1:0] fr;
    pick = $urandom_range(0, 99);
    va   = $urandom;
    idx  = IDX_W'($urandom);
    vp   = VPAGE_W'($urandom);
    ev   = ($urandom_range(0, 4) != 0);
    fr   = ($urandom_range(0, 3) != 0) ? FRAME_W'($urandom_range(0, FRAME_COUNT - 1))
                                       : FRAME_W'($urandom);
    if (pick < 14) begin
      op = OP_WRITE_TLB;
      if ($urandom_range(0, 9) != 0) idx = IDX_W'($urandom_range(0, TLB_SLOTS - 1));
      if ($urandom_range(0, 1) == 0) vp = VPAGE_W'($urandom_range(0, HOT_PAGES - 1));
    end else if (pick < 28) begin
      op = OP_WRITE_TABLE;
    end else if (pick < 95) begin
      op = OP_TRANSLATE;
      case ($urandom_range(0, 4))
        0, 1: va = {VPAGE_W'($urandom_range(0, HOT_PAGES - 1)), PAGE_SHIFT'($urandom)};
        2, 3: va = {tlb_page[$urandom_range(0, TLB_SLOTS - 1)], PAGE_SHIFT'($urandom)};
        default: ;
      endcase
    end else begin
      op = OP_UNUSED;
    end
    send_word(op, va, idx, ev, vp, fr);
  endtask

  // Both stores and registers come out of reset empty.
  task automatic test_reset_state();
    translate_addr(32'h0000_0000);
    translate_addr(32'hFFFF_FFFF);
    drain_translations();
    write_register(REG_USE_TLB, 32'd1);
    translate_addr(32'h0000_0000);
    drain_translations();
  endtask

  // Linear table: hits, invalid entries, frame bound and table bound.
  task automatic test_table_walk();
    write_register(REG_USE_TLB, 32'd0);
    write_register(REG_PT_LEN, 32'd64);
    send_word(OP_WRITE_TABLE, '0, 6'd0, 1'b1, '0, 8'd0);
    send_word(OP_WRITE_TABLE, '0, 6'd63, 1'b1, '0, 8'd31);
    send_word(OP_WRITE_TABLE, '0, 6'd5, 1'b0, '0, 8'd3);
    // The page field of a table load is don't-care.
    send_word(OP_WRITE_TABLE, '1, 6'd6, 1'b1, '1, 8'd32);
    translate_addr(32'd0);
    translate_addr(32'd8191);
    translate_addr(32'd5 * PAGE_BYTES);
    translate_addr(32'd6 * PAGE_BYTES + 32'd1);
    translate_addr(32'd64 * PAGE_BYTES);
    send_word(OP_UNUSED, '1, '1, 1'b1, '1, '1);
    drain_translations();
    // A length beyond the table still stops at the last entry.
    write_register(REG_PT_LEN, 32'd127);
    translate_addr(32'd100 * PAGE_BYTES);
    drain_translations();
    write_register(REG_PT_LEN, 32'd10);
    translate_addr(32'd63 * PAGE_BYTES);
    drain_translations();
  endtask

  // TLB: first match wins, invalid slots, frame bound, ignored slot index.
  task automatic test_tlb_lookup();
    write_register(REG_USE_TLB, 32'd1);
    send_word(OP_WRITE_TLB, '0, 6'd0, 1'b1, '1, 8'd1);
    send_word(OP_WRITE_TLB, '0, 6'd1, 1'b1, '1, 8'd2);
    send_word(OP_WRITE_TLB, '0, 6'd2, 1'b1, 25'd9, 8'd255);
    send_word(OP_WRITE_TLB, '0, 6'd3, 1'b0, 25'd5, 8'd3);
    send_word(OP_WRITE_TLB, '0, 6'd63, 1'b1, 25'd7, 8'd4);
    translate_addr(32'hFFFF_FFFF);
    translate_addr(32'd9 * PAGE_BYTES);
    translate_addr(32'd5 * PAGE_BYTES);
    translate_addr(32'd7 * PAGE_BYTES);
    send_word(OP_WRITE_TLB, '0, 6'd0, 1'b0, '1, 8'd1);
    translate_addr(32'hFFFF_FFFF);
    drain_translations();
  endtask

  // Random traffic over several register settings.
  task automatic test_random_traffic();
    int lengths [8];
    lengths = '{64, 64, 127, 63, 1, 0, 64, 64};
    lengths[6] = $urandom_range(0, 127);
    for (int phase = 0; phase < 8; phase++) begin
      drain_translations();
      write_register(REG_USE_TLB, phase % 2);
      write_register(REG_PT_LEN, lengths[phase]);
      jitter_on = (phase % 3 != 2);
      repeat (190) send_random_word();
    end
    drain_translations();
  endtask

  // Result channel held off while words keep coming, so the input stalls.
  task automatic test_backpressure();
    jitter_on = 1'b0;
    write_register(REG_USE_TLB, 32'd0);
    write_register(REG_PT_LEN, 32'd64);
    hold_left = 300;
    repeat (40) translate_addr({VPAGE_W'($urandom_range(0, HOT_PAGES - 1)),
                                PAGE_SHIFT'($urandom)});
    drain_translations();
  endtask

  // Closing stretch at full rate in both modes.
  task automatic test_full_rate();
    jitter_on = 1'b0;
    write_register(REG_USE_TLB, 32'd0);
    write_register(REG_PT_LEN, 32'd64);
    repeat (200) send_random_word();
    drain_translations();
    write_register(REG_USE_TLB, 32'd1);
    repeat (200) send_random_word();
    drain_translations();
  endtask

  initial begin
    rst                    <= 1'b1;
    cmd.valid              <= 1'b0;
    cmd.operation          <= OP_TRANSLATE;
    cmd.virtual_address    <= '0;
    cmd.entry_index        <= '0;
    cmd.entry_valid        <= 1'b0;
    cmd.entry_virtual_page <= '0;
    cmd.entry_frame        <= '0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_table_walk();
    test_tlb_lookup();
    test_random_traffic();
    test_backpressure();
    test_full_rate();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (translation_q.size() != 0)
      log_mismatch($sformatf("%0d translations never returned", translation_q.size()));
    if (mismatches == 0) begin
      $display("virtual_to_physical_translate verification clean");
    end else begin
      $display("virtual_to_physical_translate verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4000000;
    $display("virtual_to_physical_translate verification failed");
    $finish;
  end

endmodule
